[hdl/tts_pkg.sv]
`default_nettype none
package tts_pkg;

    // Slot states.
    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } t_slot_state;

    // Operation codes.
    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_SCHEDULE = 3'd1;
    localparam logic [2:0] OP_EXIT     = 3'd2;
    localparam logic [2:0] OP_BLOCK    = 3'd3;
    localparam logic [2:0] OP_WAKE     = 3'd4;

    // Result status codes.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_NONE      = 3'd2;
    localparam logic [2:0] STS_EXHAUSTED = 3'd3;
    localparam logic [2:0] STS_NOT_BLKD  = 3'd4;

    // Scheduling policies.
    localparam logic [1:0] POL_RR      = 2'd0;
    localparam logic [1:0] POL_PRIO    = 2'd1;
    localparam logic [1:0] POL_LOTTERY = 2'd2;

    // Register indexes.
    localparam int REG_POLICY = 0;

    localparam int TICKET_W = 24;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_MOD,
        SQ_SCAN,
        SQ_COMMIT,
        SQ_DONE
    } t_seq_state;

    // Control from the sequencer to the modulo unit.
    typedef struct packed {
        logic start;
    } t_mod_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage
`default_nettype wire

[hdl/tts_if.sv]
`default_nettype none
interface tts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  priority_req;
    logic [23:0] random_value;
    logic [3:0]  target_slot;
    modport source (output valid, op, priority_req, random_value, target_slot, input ready);
    modport sink (input valid, op, priority_req, random_value, target_slot, output ready);
endinterface

interface tts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] slot_index;
    modport source (output valid, status, slot_index, input ready);
    modport sink (input valid, status, slot_index, output ready);
endinterface
`default_nettype wire

[hdl/tts_mod.sv]
`default_nettype none
// Restoring modulo, one quotient bit per cycle.
module tts_mod (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  tts_pkg::t_mod_ctrl       i_ctrl,
    input  wire [tts_pkg::TICKET_W-1:0] i_num,
    input  wire [tts_pkg::TICKET_W-1:0] i_den,
    output tts_pkg::t_mod_stat       o_stat,
    output logic [tts_pkg::TICKET_W-1:0] o_rem
);
    localparam int W = tts_pkg::TICKET_W;

    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_num, n_num;
    logic [$clog2(W+1)-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [W:0] w_shift;

    // One shift-and-subtract step.
    always_comb begin
        w_shift = {r_rem, r_num[W-1]};
        n_rem = r_rem;
        n_num = r_num;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_rem = '0;
            n_num = i_num;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, i_den}) begin
                n_rem = W'(w_shift - {1'b0, i_den});
            end else begin
                n_rem = w_shift[W-1:0];
            end
            n_num = {r_num[W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ($clog2(W+1))'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
    end

    assign o_rem = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy)) else $error("done while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_den != '0) |-> (r_rem < i_den)) else $error("remainder too large");
endmodule
`default_nettype wire

[hdl/thread_table_scheduler.sv]
`default_nettype none
// Each transaction passes through the mod, scan, commit and done states (one slot scanned per cycle).
// Schedule and exit in lottery mode also wait in the mod state for the bit-serial modulo.
// Throughput: one transaction at a time; a new one is taken once the result has been taken.
// No new transaction is accepted while a result still waits in the output register.
// Synchronous active-low reset: slot 0 running at top level, the others unused, policy 0.
module thread_table_scheduler #(
    parameter int SLOTS = 16,
    parameter int TOP_LEVEL = 15
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tts_in_if.sink     i_req,
    tts_out_if.source  o_rsp,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [0:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int W = tts_pkg::TICKET_W;
    localparam logic [7:0] TOP = 8'(TOP_LEVEL);
    localparam logic [7:0] HALF = 8'(TOP_LEVEL / 2);

    // Configuration register.
    logic [1:0] r_policy;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= tts_pkg::POL_RR;
        end else if (psel && penable && pwrite && paddr == 1'(tts_pkg::REG_POLICY)) begin
            r_policy <= pwdata[1:0];
        end
    end
    assign prdata = {30'd0, r_policy};

    // Slot table.
    tts_pkg::t_slot_state r_st [SLOTS];
    logic [7:0] r_base [SLOTS];
    logic [7:0] r_aged [SLOTS];
    logic [W-1:0] r_tf [SLOTS];
    logic [W-1:0] r_tl [SLOTS];
    logic [W-1:0] r_total;
    logic [SW-1:0] r_run;

    // Transaction registers.
    tts_pkg::t_seq_state r_sq, n_sq;
    logic [2:0] r_op;
    logic [7:0] r_prio;
    logic [W-1:0] r_draw;
    logic [3:0] r_tgt;
    logic [SW:0] r_i;
    logic r_found;
    logic [SW-1:0] r_best;
    logic [7:0] r_hi;
    logic r_ovalid;
    logic [2:0] r_status;
    logic [3:0] r_slot;

    tts_pkg::t_mod_ctrl w_mctl;
    tts_pkg::t_mod_stat w_mst;
    logic [W-1:0] w_rem;
    logic [W-1:0] w_win;
    logic w_sched;

    tts_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_mctl),
        .i_num(r_draw), .i_den(r_total), .o_stat(w_mst), .o_rem(w_rem)
    );

    assign w_sched = (r_op == tts_pkg::OP_SCHEDULE) || (r_op == tts_pkg::OP_EXIT);
    assign w_win = w_rem + 1'b1;

    // Scan index as a slot index, plus round-robin rotation.
    logic [SW-1:0] w_idx;
    logic [SW:0] w_rr;
    always_comb begin
        w_rr = {1'b0, r_run} + r_i;
        if (w_rr >= (SW+1)'(SLOTS)) begin
            w_rr = w_rr - (SW+1)'(SLOTS);
        end
        if (w_sched && r_policy != tts_pkg::POL_PRIO && r_policy != tts_pkg::POL_LOTTERY) begin
            w_idx = w_rr[SW-1:0];
        end else begin
            w_idx = r_i[SW-1:0];
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_sq = r_sq;
        case (r_sq)
            tts_pkg::SQ_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_sq = tts_pkg::SQ_MOD;
                end
            end
            tts_pkg::SQ_MOD: begin
                if (!(w_sched && r_policy == tts_pkg::POL_LOTTERY) || w_mst.done
                    || r_total == '0) begin
                    n_sq = tts_pkg::SQ_SCAN;
                end
            end
            tts_pkg::SQ_SCAN: begin
                if (r_i == (SW+1)'(SLOTS - 1)) begin
                    n_sq = tts_pkg::SQ_COMMIT;
                end
            end
            tts_pkg::SQ_COMMIT: n_sq = tts_pkg::SQ_DONE;
            tts_pkg::SQ_DONE: n_sq = tts_pkg::SQ_IDLE;
            default: n_sq = tts_pkg::SQ_IDLE;
        endcase
    end

    // Output decodes of the sequencer.
    always_comb begin
        i_req.ready = (r_sq == tts_pkg::SQ_IDLE) && !r_ovalid;
        w_mctl.start = (r_sq == tts_pkg::SQ_MOD) && w_sched
            && r_policy == tts_pkg::POL_LOTTERY && r_total != '0
            && !w_mst.busy && !w_mst.done;
    end

    logic [7:0] w_aged_inc;
    logic [W:0] w_sum;
    assign w_aged_inc = (r_aged[w_idx] >= TOP) ? TOP : 8'(r_aged[w_idx] + 8'd1);
    assign w_sum = {1'b0, r_total} + {{(W-7){1'b0}}, r_prio};

    // Status and slot of the transaction, decided from the scan outcome.
    logic [2:0] w_status;
    logic [3:0] w_slot;
    logic w_tgt_blkd;
    always_comb begin
        w_tgt_blkd = ({1'b0, r_tgt} < 5'(SLOTS))
            && (r_st[SW'(r_tgt)] == tts_pkg::ST_BLOCKED);
        w_status = tts_pkg::STS_OK;
        w_slot = 4'(r_run);
        if (r_op == tts_pkg::OP_CREATE) begin
            w_slot = 4'd0;
            if (!r_found) begin
                w_status = tts_pkg::STS_FULL;
            end else if (w_sum[W]) begin
                w_status = tts_pkg::STS_EXHAUSTED;
            end else begin
                w_slot = 4'(r_best);
            end
        end else if (w_sched) begin
            if (!r_found) begin
                w_status = tts_pkg::STS_NONE;
            end else begin
                w_slot = 4'(r_best);
            end
        end else if (r_op == tts_pkg::OP_BLOCK) begin
            if (r_st[r_run] != tts_pkg::ST_RUNNING && r_st[r_run] != tts_pkg::ST_READY) begin
                w_status = tts_pkg::STS_NONE;
            end
        end else if (r_op == tts_pkg::OP_WAKE) begin
            w_slot = r_tgt;
            if (!w_tgt_blkd) begin
                w_status = tts_pkg::STS_NOT_BLKD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= tts_pkg::SQ_IDLE;
            r_ovalid <= 1'b0;
            r_run <= '0;
            r_total <= W'(TOP_LEVEL);
            for (int k = 0; k < SLOTS; k++) begin
                r_st[k] <= (k == 0) ? tts_pkg::ST_RUNNING : tts_pkg::ST_UNUSED;
                r_base[k] <= (k == 0) ? TOP : 8'd0;
                r_aged[k] <= (k == 0) ? TOP : 8'd0;
                r_tf[k] <= (k == 0) ? W'(1) : '0;
                r_tl[k] <= (k == 0) ? W'(TOP_LEVEL) : '0;
            end
        end else begin
            r_sq <= n_sq;
            // The result is raised when the sequencer finishes and held until taken.
            if (r_sq == tts_pkg::SQ_DONE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_sq)
                tts_pkg::SQ_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op <= i_req.op;
                        r_prio <= (i_req.priority_req < 8'd1 || i_req.priority_req > TOP)
                            ? HALF : i_req.priority_req;
                        r_draw <= i_req.random_value;
                        r_tgt <= i_req.target_slot;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_best <= '0;
                        r_hi <= '0;
                    end
                end
                tts_pkg::SQ_MOD: begin
                    // Exit frees the current slot, unless it is slot 0, before the selection scan.
                    if (n_sq == tts_pkg::SQ_SCAN && r_op == tts_pkg::OP_EXIT && r_run != '0) begin
                        r_st[r_run] <= tts_pkg::ST_UNUSED;
                    end
                end
                tts_pkg::SQ_SCAN: begin
                    r_i <= r_i + 1'b1;
                    if (r_op == tts_pkg::OP_CREATE) begin
                        if (!r_found && r_st[w_idx] == tts_pkg::ST_UNUSED) begin
                            r_found <= 1'b1;
                            r_best <= w_idx;
                        end
                    end else if (w_sched) begin
                        if (r_policy == tts_pkg::POL_PRIO) begin
                            if (r_st[w_idx] == tts_pkg::ST_READY) begin
                                r_aged[w_idx] <= w_aged_inc;
                                if (w_aged_inc >= r_hi) begin
                                    r_hi <= w_aged_inc;
                                    r_found <= 1'b1;
                                    r_best <= w_idx;
                                end
                            end
                        end else if (r_policy == tts_pkg::POL_LOTTERY) begin
                            if (!r_found && r_total != '0
                                && (r_st[w_idx] == tts_pkg::ST_READY
                                    || r_st[w_idx] == tts_pkg::ST_RUNNING)
                                && w_win >= r_tf[w_idx] && w_win <= r_tl[w_idx]) begin
                                r_found <= 1'b1;
                                r_best <= w_idx;
                            end
                        end else begin
                            if (!r_found && r_st[w_idx] == tts_pkg::ST_READY) begin
                                r_found <= 1'b1;
                                r_best <= w_idx;
                            end
                        end
                    end
                end
                tts_pkg::SQ_COMMIT: begin
                    r_status <= w_status;
                    r_slot <= w_slot;
                    if (w_status == tts_pkg::STS_OK) begin
                        if (r_op == tts_pkg::OP_CREATE) begin
                            r_st[r_best] <= tts_pkg::ST_READY;
                            r_base[r_best] <= r_prio;
                            r_aged[r_best] <= r_prio;
                            r_tf[r_best] <= r_total + 1'b1;
                            r_tl[r_best] <= w_sum[W-1:0];
                            r_total <= w_sum[W-1:0];
                        end else if (w_sched) begin
                            if (r_st[r_best] == tts_pkg::ST_READY) begin
                                r_aged[r_best] <= r_base[r_best];
                            end
                            // The former running thread goes back to ready.
                            if (r_st[r_run] == tts_pkg::ST_RUNNING && r_run != r_best) begin
                                r_st[r_run] <= tts_pkg::ST_READY;
                            end
                            r_st[r_best] <= tts_pkg::ST_RUNNING;
                            r_run <= r_best;
                        end else if (r_op == tts_pkg::OP_BLOCK) begin
                            r_st[r_run] <= tts_pkg::ST_BLOCKED;
                        end else if (r_op == tts_pkg::OP_WAKE) begin
                            r_st[SW'(r_tgt)] <= tts_pkg::ST_READY;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_status;
    assign o_rsp.slot_index = r_slot;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq == tts_pkg::SQ_IDLE && r_st[r_run] != tts_pkg::ST_UNUSED
         && r_st[r_run] != tts_pkg::ST_BLOCKED) |-> r_st[r_run] == tts_pkg::ST_RUNNING
         || r_st[r_run] == tts_pkg::ST_READY) else $error("bad running slot");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_sq == tts_pkg::SQ_IDLE) else $error("ready outside idle");
    a_done_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq == tts_pkg::SQ_DONE && !r_ovalid) |=> r_ovalid) else $error("result lost");
endmodule
`default_nettype wire

[bench/thread_table_scheduler_test.sv]
module thread_table_scheduler_test;

    localparam int NSLOT = 16;
    localparam int TOP = 15;
    localparam int CYCLE_LIMIT = 400000;

    // Predicted result of one transaction.
    typedef struct {
        logic [2:0] status;
        logic [3:0] slot_index;
    } t_sched_result;

    // Scoreboard: keeps its own copy of the slot table and the queue of
    // results still awaited from the block.
    class sched_scoreboard;
        tts_pkg::t_slot_state state_of[NSLOT];
        logic [7:0]  base_of[NSLOT];
        logic [7:0]  aged_of[NSLOT];
        logic [23:0] first_of[NSLOT];
        logic [23:0] last_of[NSLOT];
        logic [23:0] ticket_sum;
        logic [3:0]  current;
        logic [1:0]  policy;
        t_sched_result awaited[$];
        int errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                state_of[i] = tts_pkg::ST_UNUSED;
                base_of[i] = 8'd0;
                aged_of[i] = 8'd0;
                first_of[i] = 24'd0;
                last_of[i] = 24'd0;
            end
            state_of[0] = tts_pkg::ST_RUNNING;
            base_of[0] = 8'(TOP);
            aged_of[0] = 8'(TOP);
            first_of[0] = 24'd1;
            last_of[0] = 24'(TOP);
            ticket_sum = 24'(TOP);
            current = 4'd0;
            policy = tts_pkg::POL_RR;
            errors = 0;
        endfunction

        // Picks the next thread under the current policy; -1 if none.
        function int pick_next(logic [23:0] draw);
            int best;
            int hi;
            int lvl;
            int idx;
            logic [23:0] win;
            best = -1;
            if (policy == tts_pkg::POL_PRIO) begin
                hi = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (state_of[i] == tts_pkg::ST_READY) begin
                        lvl = aged_of[i] + 1;
                        if (lvl > TOP) lvl = TOP;
                        aged_of[i] = 8'(lvl);
                        if (lvl >= hi) begin
                            hi = lvl;
                            best = i;
                        end
                    end
                end
                return best;
            end
            if (policy == tts_pkg::POL_LOTTERY) begin
                if (ticket_sum == 24'd0) return -1;
                win = (draw % ticket_sum) + 24'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    if ((state_of[i] == tts_pkg::ST_READY || state_of[i] == tts_pkg::ST_RUNNING) &&
                        win >= first_of[i] && win <= last_of[i])
                        return i;
                end
                return -1;
            end
            for (int i = 0; i < NSLOT; i++) begin
                idx = (current + i) % NSLOT;
                if (state_of[idx] == tts_pkg::ST_READY) return idx;
            end
            return -1;
        endfunction

        function t_sched_result switch_thread(logic [23:0] draw);
            t_sched_result r;
            int sel;
            sel = pick_next(draw);
            if (sel < 0) begin
                r.status = tts_pkg::STS_NONE;
                r.slot_index = current;
                return r;
            end
            if (state_of[sel] == tts_pkg::ST_READY) aged_of[sel] = base_of[sel];
            if (state_of[current] == tts_pkg::ST_RUNNING) state_of[current] = tts_pkg::ST_READY;
            state_of[sel] = tts_pkg::ST_RUNNING;
            current = 4'(sel);
            r.status = tts_pkg::STS_OK;
            r.slot_index = 4'(sel);
            return r;
        endfunction

        // Notes an accepted request and queues the result it must give.
        function void note_request(logic [2:0] op, logic [7:0] prio,
                                   logic [23:0] draw, logic [3:0] target);
            t_sched_result r;
            int free_slot;
            logic [24:0] sum;
            r.status = tts_pkg::STS_OK;
            r.slot_index = current;
            case (op)
                tts_pkg::OP_CREATE: begin
                    free_slot = -1;
                    if (prio < 8'd1 || prio > 8'(TOP)) prio = 8'(TOP / 2);
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (state_of[i] == tts_pkg::ST_UNUSED) free_slot = i;
                    sum = {1'b0, ticket_sum} + {17'd0, prio};
                    if (free_slot < 0) begin
                        r.status = tts_pkg::STS_FULL;
                        r.slot_index = 4'd0;
                    end else if (sum > 25'hFFFFFF) begin
                        r.status = tts_pkg::STS_EXHAUSTED;
                        r.slot_index = 4'd0;
                    end else begin
                        state_of[free_slot] = tts_pkg::ST_READY;
                        base_of[free_slot] = prio;
                        aged_of[free_slot] = prio;
                        first_of[free_slot] = ticket_sum + 24'd1;
                        last_of[free_slot] = sum[23:0];
                        ticket_sum = sum[23:0];
                        r.slot_index = 4'(free_slot);
                    end
                end
                tts_pkg::OP_SCHEDULE: r = switch_thread(draw);
                tts_pkg::OP_EXIT: begin
                    if (current != 4'd0) state_of[current] = tts_pkg::ST_UNUSED;
                    r = switch_thread(draw);
                end
                tts_pkg::OP_BLOCK: begin
                    if (state_of[current] == tts_pkg::ST_RUNNING
                        || state_of[current] == tts_pkg::ST_READY)
                        state_of[current] = tts_pkg::ST_BLOCKED;
                    else
                        r.status = tts_pkg::STS_NONE;
                end
                tts_pkg::OP_WAKE: begin
                    r.slot_index = target;
                    if (state_of[target] == tts_pkg::ST_BLOCKED)
                        state_of[target] = tts_pkg::ST_READY;
                    else
                        r.status = tts_pkg::STS_NOT_BLKD;
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        // Compares one result taken from the block with the oldest prediction.
        task check_result(logic [2:0] status, logic [3:0] slot_index);
            t_sched_result r;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d", status, slot_index));
                return;
            end
            r = awaited.pop_front();
            if (status !== r.status)
                report_mismatch($sformatf("status %0d, predicted %0d", status, r.status));
            if (slot_index !== r.slot_index)
                report_mismatch($sformatf("slot %0d, predicted %0d",
                                          slot_index, r.slot_index));
        endtask

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tts_in_if  req_if ();
    tts_out_if rsp_if ();

    thread_table_scheduler #(.SLOTS(NSLOT), .TOP_LEVEL(TOP)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    sched_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;
    int cycle_count = 0;

    // Receiver: random back-pressure, or a long hold while recv_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                board.check_result(rsp_if.status, rsp_if.slot_index);
            rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("thread_table_scheduler_test: errors");
            $finish;
        end
    end

    // Offers one request and waits until the block takes it. The valid line
    // stays high afterwards so that requests can follow back to back.
    task automatic send_request(logic [2:0] op, logic [7:0] prio,
                                logic [23:0] draw, logic [3:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op <= op;
        req_if.priority_req <= prio;
        req_if.random_value <= draw;
        req_if.target_slot <= target;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(op, prio, draw, target);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Writes the policy register over the APB port while the block is idle.
    task automatic write_policy(logic [1:0] mode);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 1'(tts_pkg::REG_POLICY);
        pwdata <= {30'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.policy = mode;
    endtask

    // Random request, weighted towards the operations that move threads around.
    task automatic random_request();
        int pick;
        logic [2:0] op;
        pick = $urandom_range(99);
        if (pick < 22) op = tts_pkg::OP_CREATE;
        else if (pick < 50) op = tts_pkg::OP_SCHEDULE;
        else if (pick < 62) op = tts_pkg::OP_EXIT;
        else if (pick < 76) op = tts_pkg::OP_BLOCK;
        else if (pick < 97) op = tts_pkg::OP_WAKE;
        else op = 3'($urandom_range(5, 7));
        send_request(op, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, TOP)),
                     24'($urandom), 4'($urandom));
    endtask

    initial begin
        logic [1:0] modes[4];
        req_if.valid = 1'b0;
        req_if.op = tts_pkg::OP_CREATE;
        req_if.priority_req = '0;
        req_if.random_value = '0;
        req_if.target_slot = '0;
        // Policy value 3 is outside the named set and behaves as round robin.
        modes = '{tts_pkg::POL_PRIO, tts_pkg::POL_LOTTERY, 2'd3, tts_pkg::POL_RR};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad priorities, extremes, every op and the corner cases.
        send_request(tts_pkg::OP_BLOCK, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_SCHEDULE, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_WAKE, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_CREATE, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_CREATE, 8'd255, 24'd0, 4'd0);
        send_request(tts_pkg::OP_CREATE, 8'd1, 24'd0, 4'd0);
        send_request(tts_pkg::OP_CREATE, 8'd15, 24'd0, 4'd0);
        send_request(tts_pkg::OP_CREATE, 8'd16, 24'd0, 4'd0);
        send_request(tts_pkg::OP_WAKE, 8'd0, 24'd0, 4'd15);
        send_request(3'd7, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_SCHEDULE, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_BLOCK, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_BLOCK, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_SCHEDULE, 8'd0, 24'd0, 4'd0);
        send_request(tts_pkg::OP_WAKE, 8'd0, 24'd0, 4'd1);
        send_request(tts_pkg::OP_EXIT, 8'd0, 24'hFFFFFF, 4'd0);
        for (int i = 0; i < 12; i++) send_request(tts_pkg::OP_CREATE, 8'd255, 24'd0, 4'd0);
        send_request(tts_pkg::OP_EXIT, 8'd0, 24'd0, 4'd0);

        // Random phases across every policy and idle pattern.
        for (int ph = 0; ph < 4; ph++) begin
            write_policy(modes[ph]);
            for (int k = 0; k < 175; k++) begin
                if (k < 60) begin
                    send_idle_pct = 35;
                    recv_idle_pct = 79;
                end else if (k < 120) begin
                    send_idle_pct = 79;
                    recv_idle_pct = 35;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (ph == 1 && k == 130) begin
                    fork
                        begin
                            recv_hold = 1'b1;
                            repeat (300) @(posedge i_clk);
                            recv_hold = 1'b0;
                        end
                    join_none
                end
                random_request();
            end
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        if (board.errors == 0)
            $display("thread_table_scheduler_test: clean");
        else
            $display("thread_table_scheduler_test: errors");
        $finish;
    end
endmodule
